>>> rtl/nrd_pkg.sv
`timescale 1ns / 1ps

package nrd_pkg;

	// field and register widths
	localparam int FIELD_W    = 8;
	localparam int PORT_W     = 3;
	localparam int TOPO_W     = 2;
	localparam int COLS_W     = 8;
	localparam int ROWS_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// divider datapath
	localparam int DIV_W   = 9;
	localparam int CMP_W   = 10;
	localparam int N_LANE  = 4;
	localparam int STEPS   = 2;

	localparam int ID_BITS_DEF = 8;

	// divider lanes
	localparam int LANE_DST_GRID = 0;
	localparam int LANE_ME_GRID  = 1;
	localparam int LANE_DST_RING = 2;
	localparam int LANE_ME_RING  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOPOLOGY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NODE_ID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd3;

	// topology codes
	localparam logic [TOPO_W-1:0] TOPO_MESH  = 2'd0;
	localparam logic [TOPO_W-1:0] TOPO_TORUS = 2'd1;
	localparam logic [TOPO_W-1:0] TOPO_RING  = 2'd2;

	// output port codes
	localparam logic [PORT_W-1:0] PORT_LOCAL = 3'd0;
	localparam logic [PORT_W-1:0] PORT_NORTH = 3'd1;
	localparam logic [PORT_W-1:0] PORT_EAST  = 3'd2;
	localparam logic [PORT_W-1:0] PORT_SOUTH = 3'd3;
	localparam logic [PORT_W-1:0] PORT_WEST  = 3'd4;

	// reset values
	localparam logic [TOPO_W-1:0] TOPO_RST = TOPO_MESH;
	localparam logic [COLS_W-1:0] COLS_RST = 8'd4;
	localparam logic [ROWS_W-1:0] ROWS_RST = 9'd4;

	typedef struct packed {
		logic [TOPO_W-1:0] topology;
		logic [COLS_W-1:0] cols_div;   // column count, zero taken as one
		logic [ROWS_W-1:0] rows;       // raw row count
		logic [DIV_W-1:0]  ring_n;     // ring size, zero taken as one
	} nrd_cfg_t;

	function automatic int id_width(input int id_bits);
		return (id_bits < FIELD_W) ? id_bits : FIELD_W;
	endfunction

	function automatic int div_stages(input int id_bits);
		return (id_width(id_bits) + STEPS - 1) / STEPS;
	endfunction

endpackage

>>> rtl/nrd_cfg_regs.sv
`timescale 1ns / 1ps

module nrd_cfg_regs #(
	parameter int IW = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nrd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [IW-1:0]                   node_id,
	output nrd_pkg::nrd_cfg_t               cfg
);

	logic [nrd_pkg::TOPO_W-1:0] topology_q;
	logic [IW-1:0]              node_q;
	logic [nrd_pkg::COLS_W-1:0] cols_q;
	logic [nrd_pkg::ROWS_W-1:0] rows_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topology_q <= nrd_pkg::TOPO_RST;
			node_q     <= '0;
			cols_q     <= nrd_pkg::COLS_RST;
			rows_q     <= nrd_pkg::ROWS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nrd_pkg::REG_TOPOLOGY: topology_q <= cfg_data[nrd_pkg::TOPO_W-1:0];
				nrd_pkg::REG_NODE_ID:  node_q     <= cfg_data[IW-1:0];
				nrd_pkg::REG_COLS:     cols_q     <= cfg_data[nrd_pkg::COLS_W-1:0];
				nrd_pkg::REG_ROWS:     rows_q     <= cfg_data[nrd_pkg::ROWS_W-1:0];
			endcase
		end
	end

	assign node_id      = node_q;
	assign cfg.topology = topology_q;
	assign cfg.cols_div = (cols_q == '0) ? nrd_pkg::COLS_W'(1) : cols_q;
	assign cfg.rows     = rows_q;
	assign cfg.ring_n   = (rows_q == '0) ? nrd_pkg::DIV_W'(1) : nrd_pkg::DIV_W'(rows_q);

endmodule

>>> rtl/nrd_div_pipe.sv
`timescale 1ns / 1ps

// Restoring divider, four lanes in parallel, STEPS quotient bits per stage.
// Lanes: destination and own id by column count, destination and own id by
// ring size.
module nrd_div_pipe #(
	parameter int IW   = 8,
	parameter int NSTG = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_vld,
	input  logic [IW-1:0]                        dest,
	input  logic [IW-1:0]                        node,
	input  nrd_pkg::nrd_cfg_t                    cfg,
	output logic                                 out_vld,
	output logic [nrd_pkg::N_LANE-1:0][IW-1:0]   quo,
	output logic [nrd_pkg::N_LANE-1:0][IW-1:0]   rem
);

	localparam int DW = NSTG * nrd_pkg::STEPS;

	// index 0 is the incoming item, index k the register after stage k
	logic [NSTG:0]                                     div_vld_s;
	logic [NSTG:0][nrd_pkg::N_LANE-1:0][IW-1:0]        div_rem_s;
	logic [NSTG:0][nrd_pkg::N_LANE-1:0][DW-1:0]        div_dq_s;
	logic [NSTG-1:0][nrd_pkg::N_LANE-1:0][IW-1:0]      nxt_rem;
	logic [NSTG-1:0][nrd_pkg::N_LANE-1:0][DW-1:0]      nxt_dq;
	logic [nrd_pkg::N_LANE-1:0][nrd_pkg::DIV_W-1:0]    divisor;

	assign divisor[nrd_pkg::LANE_DST_GRID] = nrd_pkg::DIV_W'(cfg.cols_div);
	assign divisor[nrd_pkg::LANE_ME_GRID]  = nrd_pkg::DIV_W'(cfg.cols_div);
	assign divisor[nrd_pkg::LANE_DST_RING] = cfg.ring_n;
	assign divisor[nrd_pkg::LANE_ME_RING]  = cfg.ring_n;

	assign div_vld_s[0] = in_vld;
	assign div_rem_s[0] = '0;
	assign div_dq_s[0][nrd_pkg::LANE_DST_GRID] = DW'(dest);
	assign div_dq_s[0][nrd_pkg::LANE_ME_GRID]  = DW'(node);
	assign div_dq_s[0][nrd_pkg::LANE_DST_RING] = DW'(dest);
	assign div_dq_s[0][nrd_pkg::LANE_ME_RING]  = DW'(node);

	for (genvar k = 0; k < NSTG; k++) begin : g_stage
		always_comb begin : step
			logic [IW-1:0]            r;
			logic [DW-1:0]            q;
			logic [nrd_pkg::CMP_W-1:0] t;
			logic [nrd_pkg::CMP_W-1:0] d;
			for (int l = 0; l < nrd_pkg::N_LANE; l++) begin
				r = div_rem_s[k][l];
				q = div_dq_s[k][l];
				d = nrd_pkg::CMP_W'(divisor[l]);
				for (int s = 0; s < nrd_pkg::STEPS; s++) begin
					// shift in the next dividend bit, subtract if it fits
					t = {{(nrd_pkg::CMP_W - IW - 1){1'b0}}, r, q[DW-1]};
					if (t >= d) begin
						r = IW'(t - d);
						q = {q[DW-2:0], 1'b1};
					end else begin
						r = t[IW-1:0];
						q = {q[DW-2:0], 1'b0};
					end
				end
				nxt_rem[k][l] = r;
				nxt_dq[k][l]  = q;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k+1] <= 1'b0;
			end else begin
				div_vld_s[k+1] <= div_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			div_rem_s[k+1] <= nxt_rem[k];
			div_dq_s[k+1]  <= nxt_dq[k];
		end
	end

	assign out_vld = div_vld_s[NSTG];

	for (genvar l = 0; l < nrd_pkg::N_LANE; l++) begin : g_out
		assign quo[l] = div_dq_s[NSTG][l][IW-1:0];
		assign rem[l] = div_rem_s[NSTG][l];
	end

endmodule

>>> rtl/nrd_route_sel.sv
`timescale 1ns / 1ps

// Two stages: coordinate differences and ring distance, then the port choice.
module nrd_route_sel #(
	parameter int IW = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  logic [nrd_pkg::N_LANE-1:0][IW-1:0]  quo,
	input  logic [nrd_pkg::N_LANE-1:0][IW-1:0]  rem,
	input  nrd_pkg::nrd_cfg_t                   cfg,
	output logic                                done,
	output logic [nrd_pkg::PORT_W-1:0]          out_port
);

	logic [IW-1:0]             dcol, col, drow, row, dr, mr;
	logic [nrd_pkg::DIV_W-1:0] ring_hops;
	logic                      same;

	logic                      vld_s1;
	logic                      col_gt_s1, col_lt_s1, row_gt_s1, row_lt_s1, same_s1;
	logic [IW-1:0]             col_abs_s1, row_abs_s1;
	logic [nrd_pkg::DIV_W-1:0] ring_hops_s1;

	logic                      col_short, row_short, near_cw, near_ccw, wrap;
	logic [nrd_pkg::DIV_W-1:0] quarter;
	logic [nrd_pkg::PORT_W-1:0] port_nxt;

	logic                      vld_s2;
	logic [nrd_pkg::PORT_W-1:0] port_s2;

	assign dcol = rem[nrd_pkg::LANE_DST_GRID];
	assign col  = rem[nrd_pkg::LANE_ME_GRID];
	assign drow = quo[nrd_pkg::LANE_DST_GRID];
	assign row  = quo[nrd_pkg::LANE_ME_GRID];
	assign dr   = rem[nrd_pkg::LANE_DST_RING];
	assign mr   = rem[nrd_pkg::LANE_ME_RING];

	// both remainders are below the ring size, so one wrap fixes the sign
	assign ring_hops = (dr >= mr) ? nrd_pkg::DIV_W'(dr - mr)
	                              : nrd_pkg::DIV_W'(nrd_pkg::DIV_W'(dr) + cfg.ring_n
	                                                - nrd_pkg::DIV_W'(mr));
	assign same = (quo[nrd_pkg::LANE_DST_RING] == quo[nrd_pkg::LANE_ME_RING]) && (dr == mr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		col_gt_s1    <= dcol > col;
		col_lt_s1    <= dcol < col;
		col_abs_s1   <= (dcol > col) ? (dcol - col) : (col - dcol);
		row_gt_s1    <= drow > row;
		row_lt_s1    <= drow < row;
		row_abs_s1   <= (drow > row) ? (drow - row) : (row - drow);
		same_s1      <= same;
		ring_hops_s1 <= ring_hops;
	end

	// the shorter way around a ring: twice the distance is below the ring length
	assign col_short = nrd_pkg::CMP_W'({col_abs_s1, 1'b0}) < nrd_pkg::CMP_W'(cfg.cols_div);
	assign row_short = nrd_pkg::CMP_W'({row_abs_s1, 1'b0}) < nrd_pkg::CMP_W'(cfg.rows);
	assign quarter   = cfg.ring_n >> 2;
	assign near_cw   = ring_hops_s1 <= quarter;
	assign near_ccw  = (cfg.ring_n - ring_hops_s1) <= quarter;
	assign wrap      = cfg.topology == nrd_pkg::TOPO_TORUS;

	always_comb begin
		port_nxt = nrd_pkg::PORT_LOCAL;
		case (cfg.topology)
			nrd_pkg::TOPO_RING: begin
				if (same_s1)
					port_nxt = nrd_pkg::PORT_LOCAL;
				else if (near_cw)
					port_nxt = nrd_pkg::PORT_SOUTH;
				else if (near_ccw)
					port_nxt = nrd_pkg::PORT_NORTH;
				else
					port_nxt = nrd_pkg::PORT_EAST;
			end
			default: begin
				if (col_gt_s1)
					port_nxt = (!wrap || col_short) ? nrd_pkg::PORT_EAST : nrd_pkg::PORT_WEST;
				else if (col_lt_s1)
					port_nxt = (!wrap || col_short) ? nrd_pkg::PORT_WEST : nrd_pkg::PORT_EAST;
				else if (row_gt_s1)
					port_nxt = (!wrap || row_short) ? nrd_pkg::PORT_SOUTH : nrd_pkg::PORT_NORTH;
				else if (row_lt_s1)
					port_nxt = (!wrap || row_short) ? nrd_pkg::PORT_NORTH : nrd_pkg::PORT_SOUTH;
				else
					port_nxt = nrd_pkg::PORT_LOCAL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		port_s2 <= port_nxt;
	end

	assign done     = vld_s2;
	assign out_port = port_s2;

endmodule

>>> rtl/noc_route_direction.sv
`timescale 1ns / 1ps

// Channel   Handshake               Payload
// request   start, busy             dest_node
// result    done (strobe)           out_port
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One destination per cycle; busy stays low. Each destination passes the
// restoring divider, two quotient bits per stage, and then the two routing
// stages.
// arst_n clears the valid bits and loads the register reset values.
// The receiver cannot stall: every done cycle carries one result transfer.
module noc_route_direction #(
	parameter int ID_BITS = nrd_pkg::ID_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [nrd_pkg::FIELD_W-1:0]     dest_node,
	output logic                            done,
	output logic [nrd_pkg::PORT_W-1:0]      out_port,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nrd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IW   = nrd_pkg::id_width(ID_BITS);
	localparam int NSTG = nrd_pkg::div_stages(ID_BITS);

	nrd_pkg::nrd_cfg_t                     cfg;
	logic [IW-1:0]                         node_id;
	logic                                  div_vld;
	logic [nrd_pkg::N_LANE-1:0][IW-1:0]    div_quo;
	logic [nrd_pkg::N_LANE-1:0][IW-1:0]    div_rem;

	assign busy = 1'b0;

	nrd_cfg_regs #(.IW(IW)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.node_id   (node_id),
		.cfg       (cfg)
	);

	nrd_div_pipe #(.IW(IW), .NSTG(NSTG)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.dest    (dest_node[IW-1:0]),
		.node    (node_id),
		.cfg     (cfg),
		.out_vld (div_vld),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	nrd_route_sel #(.IW(IW)) u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (div_vld),
		.quo      (div_quo),
		.rem      (div_rem),
		.cfg      (cfg),
		.done     (done),
		.out_port (out_port)
	);

endmodule

>>> rtl/nrd_checker.sv
`timescale 1ns / 1ps

module nrd_checker #(
	parameter int ID_BITS = nrd_pkg::ID_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [nrd_pkg::PORT_W-1:0]   out_port
);

	localparam int LAT = nrd_pkg::div_stages(ID_BITS) + 2;

	// every transfer in gives a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted destination produced no result");

	// no result without a transfer in at the matching edge
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching request");

	a_port_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (out_port <= nrd_pkg::PORT_WEST))
		else $error("output port code out of range");

endmodule

bind noc_route_direction nrd_checker #(.ID_BITS(ID_BITS)) u_nrd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.out_port (out_port)
);

>>> tb/noc_route_direction_test.sv
`timescale 1ns / 1ps

module noc_route_direction_test;
	import nrd_pkg::*;

	// topology code 3 has no name in the block; it routes as a mesh
	localparam logic [TOPO_W-1:0] TOPO_SPARE = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 130;

	class route_checker;
		logic [TOPO_W-1:0]  topo;
		logic [FIELD_W-1:0] node;
		logic [COLS_W-1:0]  cols;
		logic [ROWS_W-1:0]  rows;
		logic [PORT_W-1:0]  due_ports[$];
		int                 errors;

		function new();
			topo = TOPO_RST;
			node = '0;
			cols = COLS_RST;
			rows = ROWS_RST;
			errors = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_TOPOLOGY: topo = data[TOPO_W-1:0];
				REG_NODE_ID:  node = data[FIELD_W-1:0];
				REG_COLS:     cols = data[COLS_W-1:0];
				REG_ROWS:     rows = data[ROWS_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PORT_W-1:0] route_port(input logic [FIELD_W-1:0] dst);
			int  c, r, m, d, row, col, drow, dcol, n, quarter, hops;
			bit  wrap;
			m = node;
			d = dst;
			if (topo == TOPO_RING) begin
				n = (rows == 0) ? 1 : int'(rows);
				quarter = n / 4;
				if (m == d)
					return PORT_LOCAL;
				hops = (d % n + n - m % n) % n;
				if (hops <= quarter)
					return PORT_SOUTH;
				if (n - hops <= quarter)
					return PORT_NORTH;
				return PORT_EAST;
			end
			c = (cols == 0) ? 1 : int'(cols);
			r = rows;
			wrap = (topo == TOPO_TORUS);
			row = m / c;
			col = m % c;
			drow = d / c;
			dcol = d % c;
			// columns first, then rows; torus takes the strictly shorter way
			if (dcol > col)
				return (!wrap || (dcol - col) < (col + c - dcol)) ? PORT_EAST : PORT_WEST;
			if (dcol < col)
				return (!wrap || (col - dcol) < (dcol + c - col)) ? PORT_WEST : PORT_EAST;
			if (drow > row)
				return (!wrap || (drow - row) < (row + r - drow)) ? PORT_SOUTH : PORT_NORTH;
			if (drow < row)
				return (!wrap || (row - drow) < (drow + r - row)) ? PORT_NORTH : PORT_SOUTH;
			return PORT_LOCAL;
		endfunction

		function void note_dest(input logic [FIELD_W-1:0] dst);
			due_ports.push_back(route_port(dst));
		endfunction

		function void check_port(input logic [PORT_W-1:0] actual);
			logic [PORT_W-1:0] want;
			if (due_ports.size() == 0) begin
				$error("out_port expected none actual %0d", actual);
				errors++;
			end else begin
				want = due_ports.pop_front();
				if (actual !== want) begin
					$error("out_port expected %0d actual %0d", want, actual);
					errors++;
				end
			end
		endfunction

		function int pending();
			return due_ports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [FIELD_W-1:0]    dest_node = '0;
	logic                  done;
	logic [PORT_W-1:0]     out_port;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	route_checker sb = new();
	int stall_cycles = 0;

	logic [FIELD_W-1:0] cur_node;
	logic [COLS_W-1:0]  cur_cols;

	noc_route_direction dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.dest_node (dest_node),
		.done      (done),
		.out_port  (out_port),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// register writes, results and destinations in a fixed order per edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (done)
				sb.check_port(out_port);
			if (start && !busy)
				sb.note_dest(dest_node);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("noc_route_direction verification failed");
				$finish;
			end
		end
	end

	task automatic send_dest(input logic [FIELD_W-1:0] d, input int idle_pct);
		int gap;
		start <= 1'b1;
		dest_node <= d;
		do @(posedge clk); while (busy);
		gap = 0;
		while ($urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every routed destination has come back
	task automatic wait_drain();
		if (start)
			start <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input logic [TOPO_W-1:0] topo, input logic [FIELD_W-1:0] node,
			input logic [COLS_W-1:0] cols, input logic [ROWS_W-1:0] rows);
		logic [CFG_IDX_W-1:0]  idx[4];
		logic [CFG_DATA_W-1:0] val[4];
		idx = '{REG_TOPOLOGY, REG_NODE_ID, REG_COLS, REG_ROWS};
		val = '{CFG_DATA_W'(topo), CFG_DATA_W'(node), CFG_DATA_W'(cols), rows};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cur_node = node;
		cur_cols = cols;
	endtask

	task automatic run_probe(input logic [TOPO_W-1:0] topo, input logic [FIELD_W-1:0] node,
			input logic [COLS_W-1:0] cols, input logic [ROWS_W-1:0] rows,
			input logic [FIELD_W-1:0] dests[$]);
		wait_drain();
		load_config(topo, node, cols, rows);
		foreach (dests[i])
			send_dest(dests[i], 0);
	endtask

	initial begin
		int idle_pcts[4];
		int idle;
		logic [FIELD_W-1:0] d;
		logic [TOPO_W-1:0]  topo;
		logic [FIELD_W-1:0] node;
		logic [COLS_W-1:0]  cols;
		logic [ROWS_W-1:0]  rows;

		// results cannot be held off, so only the sender idles
		idle_pcts = '{0, 64, 0, 19};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// mesh at reset values, then moves in all four directions, spare code as mesh
		run_probe(TOPO_MESH, 8'd0, 8'd4, 9'd4, '{8'd0, 8'd255, 8'd5, 8'd12});
		run_probe(TOPO_MESH, 8'd10, 8'd4, 9'd4, '{8'd8, 8'd2, 8'd14, 8'd11});
		run_probe(TOPO_SPARE, 8'd10, 8'd4, 9'd4, '{8'd8, 8'd2});
		// torus ties both ways, and a row beyond the grid
		run_probe(TOPO_TORUS, 8'd0, 8'd4, 9'd4, '{8'd2, 8'd8, 8'd255, 8'd1});
		run_probe(TOPO_TORUS, 8'd2, 8'd4, 9'd4, '{8'd0});
		// zero columns act as one
		run_probe(TOPO_MESH, 8'd5, 8'd0, 9'd4, '{8'd9, 8'd5});
		// ring quarters, across link, wrap to distance zero, local
		run_probe(TOPO_RING, 8'd0, 8'd4, 9'd16, '{8'd4, 8'd12, 8'd8, 8'd16, 8'd0});
		// zero ring size acts as one
		run_probe(TOPO_RING, 8'd0, 8'd4, 9'd0, '{8'd5});
		run_probe(TOPO_RING, 8'd255, 8'd255, 9'd256, '{8'd0});

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin topo = TOPO_MESH;  node = 8'd255; cols = 8'd255; rows = 9'd256; end
				1: begin topo = TOPO_TORUS; node = 8'd0;   cols = 8'd1;   rows = 9'd1;   end
				2: begin topo = TOPO_RING;  node = 8'd255; cols = 8'd255; rows = 9'd256; end
				3: begin topo = TOPO_SPARE; node = 8'd128; cols = 8'd16;  rows = 9'd16;  end
				4: begin topo = TOPO_TORUS; node = 8'd37;  cols = 8'd255; rows = 9'd511; end
				default: begin
					topo = TOPO_W'($urandom_range(3));
					node = FIELD_W'($urandom_range(255));
					case ($urandom_range(7))
						0: cols = COLS_W'($urandom_range(255));
						1: cols = '0;
						default: cols = COLS_W'($urandom_range(1, 16));
					endcase
					case ($urandom_range(7))
						0: rows = ROWS_W'($urandom_range(511));
						1: rows = '0;
						default: rows = ROWS_W'($urandom_range(1, 16));
					endcase
				end
			endcase
			wait_drain();
			load_config(topo, node, cols, rows);
			idle = idle_pcts[ph % 4];
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				case ($urandom_range(3))
					0, 1: d = FIELD_W'($urandom_range(255));
					2: d = cur_node + FIELD_W'($urandom_range(16)) - 8'd8;
					default: d = cur_node + FIELD_W'(cur_cols * $urandom_range(3));
				endcase
				send_dest(d, idle);
				if (ph % 3 == 1 && k == PHASE_ITEMS / 2)
					wait_drain();
			end
		end

		wait_drain();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("noc_route_direction verification clean");
		end else begin
			$display("noc_route_direction verification failed");
		end
		$finish;
	end

endmodule

>>> noc_route_direction.f
rtl/nrd_pkg.sv
rtl/nrd_cfg_regs.sv
rtl/nrd_div_pipe.sv
rtl/nrd_route_sel.sv
rtl/noc_route_direction.sv
rtl/nrd_checker.sv
tb/noc_route_direction_test.sv
